>>> rtl/core/websocket_frame_unmasker_top_defines.svh
// Assertion macros shared by the websocket unmasker checker.
`ifndef WEBSOCKET_FRAME_UNMASKER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_UNMASKER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define WSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define WSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/wsu_pkg.sv
// Types and constants of the websocket frame unmasker.
`timescale 1ns / 1ps

package wsu_pkg;

    localparam int ByteW   = 8;
    localparam int KindW   = 2;
    localparam int OpcodeW = 4;
    localparam int LenW    = 64;
    localparam int KeyW    = 32;

    // Result kinds.
    localparam logic [KindW-1:0] KIND_DATA   = 2'd0;
    localparam logic [KindW-1:0] KIND_EMPTY  = 2'd1;
    localparam logic [KindW-1:0] KIND_CLOSE  = 2'd2;
    localparam logic [KindW-1:0] KIND_REJECT = 2'd3;

    // Opcodes accepted by the parser.
    localparam logic [OpcodeW-1:0] OP_CONT  = 4'h0;
    localparam logic [OpcodeW-1:0] OP_TEXT  = 4'h1;
    localparam logic [OpcodeW-1:0] OP_BIN   = 4'h2;
    localparam logic [OpcodeW-1:0] OP_CLOSE = 4'h8;

    // Length codes in the second header byte.
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_KEY,
        PH_DATA,
        PH_HALT
    } wsu_phase_t;

    typedef struct packed {
        logic [ByteW-1:0]   out_byte;
        logic [KindW-1:0]   out_kind;
        logic [OpcodeW-1:0] frame_opcode;
        logic               last_of_frame;
    } wsu_result_t;

endpackage

>>> rtl/core/wsu_in_stage.sv
// Input register of the websocket unmasker.
`timescale 1ns / 1ps

module wsu_in_stage
    import wsu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ByteW-1:0] s_tdata,
    input  logic             take,
    output logic             in_valid,
    output logic [ByteW-1:0] in_byte
);

    logic             valid_reg;
    logic             valid_next;
    logic [ByteW-1:0] byte_reg;

    // Refill in the same cycle the held byte moves on.
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

>>> rtl/core/wsu_parser.sv
// Frame header parser and payload unmasking for the websocket unmasker.
`timescale 1ns / 1ps

module wsu_parser
    import wsu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [ByteW-1:0] in_byte,
    output logic             res_valid,
    output wsu_result_t      res
);

    wsu_phase_t         phase_reg,  phase_next;
    logic [OpcodeW-1:0] opcode_reg, opcode_next;
    logic [LenW-1:0]    len_reg,    len_next;
    logic [2:0]         cnt_reg,    cnt_next;
    logic [KeyW-1:0]    key_reg,    key_next;
    logic [1:0]         kpos_reg,   kpos_next;

    logic               op_ok;
    logic               mask_ok;
    logic [6:0]         len_code;
    logic               len_is_one;
    logic [ByteW-1:0]   key_byte;

    assign op_ok = (opcode_reg == OP_CONT) || (opcode_reg == OP_TEXT) ||
                   (opcode_reg == OP_BIN)  || (opcode_reg == OP_CLOSE);
    assign mask_ok    = in_byte[7];
    assign len_code   = in_byte[6:0];
    assign len_is_one = (len_reg == {{(LenW-1){1'b0}}, 1'b1});

    // Key bytes are used first-received first.
    always_comb begin
        case (kpos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Next state and datapath registers.
    always_comb begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        kpos_next   = kpos_reg;
        unique case (phase_reg)
            PH_HDR0: begin
                opcode_next = in_byte[OpcodeW-1:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1: begin
                if (!mask_ok || !op_ok || (opcode_reg == OP_CLOSE)) begin
                    phase_next = PH_HALT;
                end else begin
                    len_next = '0;
                    key_next = '0;
                    if (len_code == LEN_CODE_16) begin
                        cnt_next   = 3'd6;
                        phase_next = PH_EXTLEN;
                    end else if (len_code == LEN_CODE_64) begin
                        cnt_next   = 3'd0;
                        phase_next = PH_EXTLEN;
                    end else begin
                        len_next   = {{(LenW-7){1'b0}}, len_code};
                        cnt_next   = 3'd0;
                        phase_next = PH_KEY;
                    end
                end
            end
            PH_EXTLEN: begin
                len_next = {len_reg[LenW-ByteW-1:0], in_byte};
                if (cnt_reg == 3'd7) begin
                    cnt_next   = 3'd0;
                    phase_next = PH_KEY;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            PH_KEY: begin
                key_next = {key_reg[KeyW-ByteW-1:0], in_byte};
                if (cnt_reg >= 3'd3) begin
                    cnt_next   = 3'd0;
                    kpos_next  = 2'd0;
                    phase_next = (len_reg == '0) ? PH_HDR0 : PH_DATA;
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            PH_DATA: begin
                len_next  = len_reg - {{(LenW-1){1'b0}}, 1'b1};
                kpos_next = kpos_reg + 2'd1;
                if (len_is_one) begin
                    kpos_next  = 2'd0;
                    phase_next = PH_HDR0;
                end
            end
            PH_HALT: begin
                phase_next = PH_HALT;
            end
            default: begin
                phase_next = PH_HALT;
            end
        endcase
    end

    // Result for the byte being parsed.
    always_comb begin
        res_valid         = 1'b0;
        res.out_byte      = '0;
        res.out_kind      = KIND_DATA;
        res.frame_opcode  = opcode_reg;
        res.last_of_frame = 1'b1;
        unique case (phase_reg)
            PH_HDR1: begin
                if (!mask_ok || !op_ok) begin
                    res_valid    = 1'b1;
                    res.out_kind = KIND_REJECT;
                end else if (opcode_reg == OP_CLOSE) begin
                    res_valid    = 1'b1;
                    res.out_kind = KIND_CLOSE;
                end
            end
            PH_KEY: begin
                if ((cnt_reg >= 3'd3) && (len_reg == '0)) begin
                    res_valid    = 1'b1;
                    res.out_kind = KIND_EMPTY;
                end
            end
            PH_DATA: begin
                res_valid         = 1'b1;
                res.out_byte      = in_byte ^ key_byte;
                res.last_of_frame = len_is_one;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            len_reg    <= '0;
            cnt_reg    <= '0;
            key_reg    <= '0;
            kpos_reg   <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            key_reg    <= key_next;
            kpos_reg   <= kpos_next;
        end
    end

endmodule

>>> rtl/core/wsu_out_stage.sv
// Result register of the websocket unmasker.
`timescale 1ns / 1ps

module wsu_out_stage
    import wsu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  wsu_result_t res,
    output logic        out_valid,
    input  logic        out_ready,
    output wsu_result_t out_res
);

    logic        valid_reg;
    wsu_result_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

>>> rtl/core/websocket_frame_unmasker_top.sv
// Top level of the websocket client-to-server frame unmasker.
//
//  channel | dir | tdata             | tuser                         | tlast
//  s_      | in  | [7:0] in_byte     | -                             | -
//  m_      | out | [7:0] out_byte    | [1:0] out_kind, [5:2] opcode  | last_of_frame
//
//  One stream byte per clock while m_tready is high; a byte passes the input
//  register, then the result register, from s_ transaction to m_tvalid.
//  Header, length and key bytes produce no m_ transaction, save close and reject
//  results on the second header byte and an empty result for a zero-length frame.
//  The parse step fires when the input register holds a byte and the result
//  register is empty or being drained; m_tready low stalls it. aresetn (sync,
//  active low) returns to the first header byte and clears the halt left by a close or reject result.
`timescale 1ns / 1ps

module websocket_frame_unmasker_top
    import wsu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ByteW-1:0] s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [ByteW-1:0] m_tdata,   // [7:0] out_byte
    output logic [5:0]       m_tuser,   // [1:0] out_kind, [5:2] frame_opcode
    output logic             m_tlast    // last_of_frame
);

    logic             in_valid;
    logic [ByteW-1:0] in_byte;
    logic             step;
    logic             res_valid;
    wsu_result_t      res;
    wsu_result_t      out_res;

    // Advance while the result slot is free or draining this cycle.
    assign step = in_valid && (!m_tvalid || m_tready);

    wsu_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (step),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    wsu_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsu_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step && res_valid),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tuser = {out_res.frame_opcode, out_res.out_kind};
    assign m_tlast = out_res.last_of_frame;

endmodule

>>> rtl/core/wsu_checker.sv
// Port-level checks for the websocket unmasker, bound to the top level.
`timescale 1ns / 1ps
`include "websocket_frame_unmasker_top_defines.svh"

module wsu_checker
    import wsu_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [ByteW-1:0] m_tdata,
    input logic [5:0]       m_tuser,
    input logic             m_tlast
);

    logic        stall;
    logic [14:0] out_word;
    logic        event_res;
    logic        close_res;
    logic        halt_res;

    assign stall     = m_tvalid && !m_tready;
    assign out_word  = {m_tlast, m_tuser, m_tdata};
    assign event_res = m_tvalid && (m_tuser[1:0] != KIND_DATA);
    assign close_res = m_tvalid && (m_tuser[1:0] == KIND_CLOSE);
    assign halt_res  = m_tvalid && ((m_tuser[1:0] == KIND_CLOSE) ||
                                    (m_tuser[1:0] == KIND_REJECT));

    `WSU_ASSERT_NEXT(a_out_hold, stall, m_tvalid && $stable(out_word), "result moved in stall")
    `WSU_ASSERT_NOW(a_event_shape, event_res, m_tlast && (m_tdata == '0), "bad event result")
    `WSU_ASSERT_NOW(a_close_opcode, close_res, m_tuser[5:2] == OP_CLOSE, "close opcode wrong")
    `WSU_ASSERT_NEXT(a_halt_quiet, halt_res && m_tready, !m_tvalid, "result after halt")
    `WSU_ASSERT_NOW(a_in_ready, !m_tvalid || m_tready, s_tready, "input stalled, slot free")

endmodule

bind websocket_frame_unmasker_top wsu_checker u_chk (.*);
